// ===== hw/rtl/sdbc_pkg.sv =====
package sdbc_pkg;

    // Attenuation register and clip level formats.
    localparam int ATT_W   = 5;
    localparam int LEVEL_W = 15;
    localparam int ATT_MAX = 30;

    typedef logic [ATT_W-1:0]   att_t;
    typedef logic [LEVEL_W-1:0] level_t;

    // Stage-one status handed from the top level to the output stage.
    typedef struct packed {
        logic valid;
        logic block_end;
    } stage_ctrl_t;

    // Clip thresholds for 0 dB down to -30 dB in whole-dB steps.
    localparam level_t LEVEL_TABLE [0:ATT_MAX] = '{
        15'd32767, 15'd29205, 15'd26030, 15'd23199, 15'd20675, 15'd18428,
        15'd16427, 15'd14637, 15'd13046, 15'd11628, 15'd10362, 15'd9238,
        15'd8233,  15'd7337,  15'd6539,  15'd5829,  15'd5194,  15'd4630,
        15'd4126,  15'd3677,  15'd3277,  15'd2920,  15'd2603,  15'd2320,
        15'd2068,  15'd1843,  15'd1642,  15'd1464,  15'd1305,  15'd1163,
        15'd1036
    };

    // Attenuation codes above the table's end read as the last entry.
    function automatic level_t clip_level(att_t att);
        att_t idx;
        idx = (att > att_t'(ATT_MAX)) ? att_t'(ATT_MAX) : att;
        return LEVEL_TABLE[idx];
    endfunction

endpackage

// ===== hw/rtl/sdbc_lane.sv =====
module sdbc_lane #(
    parameter int FILT_FRAC_BITS = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic signed [15:0]    sample_in,
    input  sdbc_pkg::level_t      level,
    output logic signed [15:0]    sample_out
);
    import sdbc_pkg::*;

    localparam int W  = 18 + FILT_FRAC_BITS;
    localparam longint unsigned ONE  = 64'd1 << FILT_FRAC_BITS;
    localparam longint unsigned HALF = ONE >> 1;
    localparam longint unsigned COEF = ((64'd999 << FILT_FRAC_BITS) + 64'd500) / 64'd1000;
    // The pole sits just below one, so R * y is formed as y - y * (1 - R).
    localparam longint unsigned DIFF = ONE - COEF;
    localparam int DW = $clog2(DIFF + 1);
    localparam int PW = W + DW;

    logic signed [15:0]  prev_in_reg;
    logic signed [W-1:0] prev_filt_reg;
    logic signed [W-1:0] prev_filt_next;

    logic                neg_prev;
    logic [W-1:0]        mag_prev;
    logic [PW-1:0]       prod;
    logic signed [PW+1:0] corr;
    logic signed [PW+1:0] corr_sh;
    logic signed [PW+1:0] scaled_wide;
    logic [W-1:0]        scaled_mag;
    logic signed [W:0]   scaled;
    logic signed [16:0]  diff_in;
    logic signed [W+1:0] y_wide;
    logic [17:0]         mag_int;
    logic [LEVEL_W-1:0]  clip_mag;

    // Magnitude of the previous filter output.
    assign neg_prev = prev_filt_reg[W-1];
    assign mag_prev = neg_prev ? W'(-prev_filt_reg) : W'(prev_filt_reg);

    // Coefficient product on the magnitude, rounded to nearest, ties away from zero.
    assign prod        = PW'(mag_prev) * PW'(DIFF[DW-1:0]);
    assign corr        = $signed({2'b00, PW'(HALF)}) - $signed({2'b00, prod});
    assign corr_sh     = corr >>> FILT_FRAC_BITS;
    assign scaled_wide = $signed({{(PW+2-W){1'b0}}, mag_prev}) + corr_sh;
    assign scaled_mag  = scaled_wide[W-1:0];
    assign scaled      = neg_prev ? -$signed({1'b0, scaled_mag}) : $signed({1'b0, scaled_mag});

    // New filter output from the input difference, saturated to the state width.
    assign diff_in = $signed({sample_in[15], sample_in}) - $signed({prev_in_reg[15], prev_in_reg});
    assign y_wide  = $signed({{3{diff_in[16]}}, diff_in, {FILT_FRAC_BITS{1'b0}}})
                   + $signed({scaled[W], scaled});

    always_comb
    begin
        if (y_wide > $signed({3'b000, {(W-1){1'b1}}}))
            prev_filt_next = $signed({1'b0, {(W-1){1'b1}}});
        else if (y_wide < $signed({3'b111, {(W-1){1'b0}}}))
            prev_filt_next = $signed({1'b1, {(W-1){1'b0}}});
        else
            prev_filt_next = y_wide[W-1:0];
    end

    // Filter state advances on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_in_reg   <= '0;
            prev_filt_reg <= '0;
        end
        else if (load)
        begin
            prev_in_reg   <= sample_in;
            prev_filt_reg <= prev_filt_next;
        end
    end

    // Truncate toward zero and clip symmetrically; the level never exceeds 32767,
    // so the 16-bit saturation is covered by the clip.
    assign mag_int  = mag_prev[W-1:FILT_FRAC_BITS];
    assign clip_mag = (mag_int > {3'b000, level}) ? level : mag_int[LEVEL_W-1:0];
    assign sample_out = neg_prev ? -$signed({1'b0, clip_mag}) : $signed({1'b0, clip_mag});

endmodule

// ===== hw/rtl/sdbc_merge.sv =====
module sdbc_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sdbc_pkg::stage_ctrl_t stage,
    input  logic signed [15:0]    left_lane,
    input  logic signed [15:0]    right_lane,
    output logic                  stage_free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [15:0]    left_out,
    output logic signed [15:0]    right_out,
    output logic                  block_end_out
);
    import sdbc_pkg::*;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;
    logic               block_end_reg;
    logic               capture;

    // The output register can take a result when empty or when its transfer completes.
    assign stage_free = !out_valid_reg || out_ready;
    assign capture    = stage.valid && stage_free;

    always_comb
    begin
        if (capture)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Both lane results and the marker are joined into one result.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            left_reg      <= left_lane;
            right_reg     <= right_lane;
            block_end_reg <= stage.block_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_out      = left_reg;
    assign right_out     = right_reg;
    assign block_end_out = block_end_reg;

endmodule

// ===== hw/rtl/stereo_dc_block_hard_clip.sv =====
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   left_sample, right_sample, block_end
// output    out        out_valid / out_ready left_out, right_out, block_end_out
// config    in         cfg_wr_en             cfg_wr_data (attenuation in dB)
//
// One stereo pair is accepted every cycle unless a stalled output has backed up into
// the filter stage. Its result is held in the filter state register and then in the
// output register, where it is offered. The rate is set by the filter feedback loop in
// each lane, one coefficient multiply and add per cycle. Reset clears the filter state,
// the attenuation register and all valid flags. A stalled output holds its result while
// one more pair can still be taken into the filter stage.
module stereo_dc_block_hard_clip #(
    parameter int FILT_FRAC_BITS = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    input  logic               block_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic               block_end_out,
    input  logic               cfg_wr_en,
    input  sdbc_pkg::att_t     cfg_wr_data
);
    import sdbc_pkg::*;

    att_t        att_reg;
    level_t      level;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_block_end_reg;
    logic        stage_free;
    logic        accept;
    stage_ctrl_t stage;
    logic signed [15:0] left_lane;
    logic signed [15:0] right_lane;

    // Attenuation register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            att_reg <= '0;
        else if (cfg_wr_en)
            att_reg <= cfg_wr_data;
    end

    assign level = clip_level(att_reg);

    // Filter stage control.
    assign in_ready = !s1_valid_reg || stage_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (stage_free)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_block_end_reg <= block_end;
    end

    assign stage.valid     = s1_valid_reg;
    assign stage.block_end = s1_block_end_reg;

    // One lane per channel.
    sdbc_lane #(
        .FILT_FRAC_BITS(FILT_FRAC_BITS)
    ) u_lane_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .sample_in  (left_sample),
        .level      (level),
        .sample_out (left_lane)
    );

    sdbc_lane #(
        .FILT_FRAC_BITS(FILT_FRAC_BITS)
    ) u_lane_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .sample_in  (right_sample),
        .level      (level),
        .sample_out (right_lane)
    );

    // Output register joins the lanes.
    sdbc_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage         (stage),
        .left_lane     (left_lane),
        .right_lane    (right_lane),
        .stage_free    (stage_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_out      (left_out),
        .right_out     (right_out),
        .block_end_out (block_end_out)
    );

endmodule

// ===== hw/rtl/sdbc_checker.sv =====
module sdbc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] left_out,
    input logic signed [15:0] right_out,
    input logic               block_end_out
);

    logic [1:0] occ_reg;
    logic [1:0] occ_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // Count of pairs taken in whose results have not yet been transferred out.
    always_comb
    begin
        occ_next = occ_reg;
        if (in_xfer && !out_xfer)
            occ_next = occ_reg + 2'd1;
        else if (out_xfer && !in_xfer)
            occ_next = occ_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    // The block holds at most two pairs in flight.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg != 2'd3)
        else $error("more than two pairs in flight");

    // A result is only offered for a pair that was taken in.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != 2'd0)
        else $error("result offered with nothing in flight");

    // An empty block always takes input.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == 2'd0 |-> in_ready)
        else $error("empty block refuses input");

    // A full block with a stalled output takes no input.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == 2'd2 && !out_ready) |-> !in_ready)
        else $error("input taken while full and stalled");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(left_out) && $stable(right_out) && $stable(block_end_out)))
        else $error("stalled result changed");

endmodule

bind stereo_dc_block_hard_clip sdbc_checker u_sdbc_checker (.*);
